// ===== sv/etr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etr_pkg
// Shared types and field widths for the event trace ring recorder.
// ----------------------------------------------------------------------------
package etr_pkg;

    localparam int TYPE_W = 16;
    localparam int WORD_W = 32;
    localparam int CNT_W  = 7;   // width of dump_limit and of a dump's entry count

    // One stored trace entry
    typedef struct packed {
        logic [WORD_W-1:0] arg_three;
        logic [WORD_W-1:0] arg_two;
        logic [WORD_W-1:0] arg_one;
        logic [WORD_W-1:0] arg_zero;
        logic [WORD_W-1:0] proc_id;
        logic [TYPE_W-1:0] event_type;
    } etr_entry_t;

    // Classified command handed from the front to the back
    typedef struct packed {
        logic              is_dump;
        logic [CNT_W-1:0]  n;        // entries to stream (dump only)
        logic [WORD_W-1:0] seq;      // sequence number of the first entry (dump only)
        etr_entry_t        entry;    // payload to store (record only)
    } etr_cmd_t;

    // One result beat
    typedef struct packed {
        logic              last;
        etr_entry_t        entry;
        logic [WORD_W-1:0] seq;
    } etr_out_t;

endpackage

// ===== sv/etr_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etr_fifo
// Small register queue between the front and the back of the recorder.
// ----------------------------------------------------------------------------
module etr_fifo #(
    parameter int DEPTH  = 4,
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  logic [DATA_W-1:0] push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output logic [DATA_W-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OCC_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [OCC_W-1:0]  occ_reg, occ_next;
    logic              do_push, do_pop;

    assign push_ready = (occ_reg != OCC_W'(DEPTH));
    assign pop_valid  = (occ_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        occ_next    = occ_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            occ_next = occ_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            occ_next = occ_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            occ_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            occ_reg    <= occ_next;
        end
    end

    // Store the pushed beat
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== sv/etr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etr_front
// Accepts input beats, tracks the record count and write slot, and turns
// each item into a record or dump command with its slot and counts resolved.
// ----------------------------------------------------------------------------
module etr_front
    import etr_pkg::*;
#(
    parameter int RING_DEPTH = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          in_dump,
    input  etr_entry_t                    in_entry,
    input  logic [CNT_W-1:0]              in_limit,
    output logic                          push_valid,
    input  logic                          push_ready,
    output logic [$clog2(RING_DEPTH)-1:0] push_slot,
    output etr_cmd_t                      push_cmd
);

    localparam int SLOT_W = $clog2(RING_DEPTH);

    logic [WORD_W-1:0] count_reg, count_next;
    logic [SLOT_W-1:0] wptr_reg, wptr_next;
    logic              accept;
    logic [CNT_W-1:0]  held;
    logic [CNT_W-1:0]  n;
    logic [CNT_W-1:0]  wptr_ext;
    logic [CNT_W-1:0]  start_ext;

    assign in_ready = push_ready;
    assign accept   = in_valid && in_ready;

    // Work out how many entries a dump returns and where it starts
    always_comb
    begin
        held      = (count_reg >= WORD_W'(RING_DEPTH)) ? CNT_W'(RING_DEPTH)
                                                       : count_reg[CNT_W-1:0];
        n         = ((in_limit != '0) && (in_limit < held)) ? in_limit : held;
        wptr_ext  = CNT_W'(wptr_reg);
        start_ext = (wptr_ext >= n) ? (wptr_ext - n)
                                    : (wptr_ext + CNT_W'(RING_DEPTH) - n);
    end

    // Build the command; drop a dump on an empty ring
    always_comb
    begin
        push_cmd.is_dump = in_dump;
        push_cmd.n       = n;
        push_cmd.seq     = count_reg - WORD_W'(n) + 1'b1;
        push_cmd.entry   = in_entry;
        push_slot        = in_dump ? start_ext[SLOT_W-1:0] : wptr_reg;
        push_valid       = in_valid && (!in_dump || (count_reg != '0));
    end

    // Advance the record count and write slot on each record
    always_comb
    begin
        count_next = count_reg;
        wptr_next  = wptr_reg;
        if (accept && !in_dump)
        begin
            count_next = count_reg + 1'b1;
            if (count_reg == '1)
            begin
                wptr_next = '0;
            end
            else if (wptr_reg == SLOT_W'(RING_DEPTH - 1))
            begin
                wptr_next = '0;
            end
            else
            begin
                wptr_next = wptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            wptr_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            wptr_reg  <= wptr_next;
        end
    end

endmodule

// ===== sv/etr_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etr_back
// Executes queued commands: writes records into the ring memory and streams
// dumps out of it through a registered read and a two-beat output buffer.
// ----------------------------------------------------------------------------
module etr_back
    import etr_pkg::*;
#(
    parameter int RING_DEPTH = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  logic [$clog2(RING_DEPTH)-1:0] cmd_slot,
    input  etr_cmd_t                      cmd,
    output logic                          out_valid,
    input  logic                          out_ready,
    output etr_out_t                      out_beat
);

    localparam int SLOT_W = $clog2(RING_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DUMP = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    logic [SLOT_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  left_reg, left_next;
    logic [WORD_W-1:0] seq_reg, seq_next;

    etr_entry_t        ring_mem [RING_DEPTH];
    etr_entry_t        rd_q_reg;
    logic              rd_vld_reg;
    logic [WORD_W-1:0] rd_seq_reg;
    logic              rd_last_reg;

    etr_out_t          buf_reg [2];
    logic              buf_wr_reg, buf_rd_reg;
    logic [1:0]        occ_reg, occ_next;

    logic              take;
    logic              wr_en;
    logic              issue;
    logic              pop;
    logic [1:0]        occ_room;

    assign cmd_ready = (state_reg == S_IDLE);
    assign take      = cmd_valid && cmd_ready;
    assign wr_en     = take && !cmd.is_dump;

    assign out_valid = (occ_reg != 2'd0);
    assign out_beat  = buf_reg[buf_rd_reg];
    assign pop       = out_valid && out_ready;

    // Issue a read only when its beat is sure to find room in the buffer
    assign occ_room  = occ_reg - {1'b0, pop} + {1'b0, rd_vld_reg};
    assign issue     = (state_reg == S_DUMP) && (occ_room < 2'd2);

    // Sequence the dump reads
    always_comb
    begin
        state_next  = state_reg;
        rd_ptr_next = rd_ptr_reg;
        left_next   = left_reg;
        seq_next    = seq_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (take && cmd.is_dump)
                begin
                    state_next  = S_DUMP;
                    rd_ptr_next = cmd_slot;
                    left_next   = cmd.n;
                    seq_next    = cmd.seq;
                end
            end
            S_DUMP:
            begin
                if (issue)
                begin
                    rd_ptr_next = (rd_ptr_reg == SLOT_W'(RING_DEPTH - 1)) ? '0
                                                                         : rd_ptr_reg + 1'b1;
                    left_next   = left_reg - 1'b1;
                    seq_next    = seq_reg + 1'b1;
                    if (left_reg == CNT_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_ptr_reg <= rd_ptr_next;
        left_reg   <= left_next;
        seq_reg    <= seq_next;
    end

    // Ring memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ring_mem[cmd_slot] <= cmd.entry;
        end
        if (issue)
        begin
            rd_q_reg    <= ring_mem[rd_ptr_reg];
            rd_seq_reg  <= seq_reg;
            rd_last_reg <= (left_reg == CNT_W'(1));
        end
    end

    // Output buffer occupancy
    always_comb
    begin
        occ_next = occ_reg;
        if (rd_vld_reg && !pop)
        begin
            occ_next = occ_reg + 2'd1;
        end
        else if (pop && !rd_vld_reg)
        begin
            occ_next = occ_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg    <= 2'd0;
            buf_wr_reg <= 1'b0;
            buf_rd_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
            if (rd_vld_reg)
            begin
                buf_wr_reg <= ~buf_wr_reg;
            end
            if (pop)
            begin
                buf_rd_reg <= ~buf_rd_reg;
            end
        end
    end

    // Land the read beat in the buffer
    always_ff @(posedge clk)
    begin
        if (rd_vld_reg)
        begin
            buf_reg[buf_wr_reg].seq   <= rd_seq_reg;
            buf_reg[buf_wr_reg].entry <= rd_q_reg;
            buf_reg[buf_wr_reg].last  <= rd_last_reg;
        end
    end

endmodule

// ===== sv/event_trace_ring_recorder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_trace_ring_recorder_unit
// Typed event trace ring with record and dump commands on a stream port.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one command per beat; s_tuser selects it
//   (0 records the event in s_tdata, 1 dumps recent entries). A record
//   overwrites the oldest entry once RING_DEPTH entries are held and bumps a
//   32-bit counter that also numbers the entries. A dump streams the last
//   min(records, RING_DEPTH, dump_limit) entries oldest first on the master
//   channel, dump_limit 0 meaning all held, with m_tlast on the final beat.
//   A dump on an empty ring produces no beat.
//   Records are taken one per cycle while the command queue has room; a
//   dump streams its entries through the single ring memory read port.
//   On an idle block the first dump beat passes the command queue, the
//   dump state, the ring read and the output buffer before m_tvalid rises.
//   A four-entry command queue lets records keep arriving while a dump
//   drains; s_tready falls only when that queue is full.
//   When m_tready is low the two-beat output buffer fills and the dump
//   reader pauses; no beat is lost.
//   Reset clears the record counter and all queues; ring contents are
//   undefined until written and need no clearing.
// ----------------------------------------------------------------------------
module event_trace_ring_recorder_unit
    import etr_pkg::*;
#(
    parameter int RING_DEPTH = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // event_type[15:0], proc_id[47:16], arg_zero[79:48], arg_one[111:80],
    // arg_two[143:112], arg_three[175:144], dump_limit[182:176], zero pad
    input  logic [183:0] s_tdata,
    input  logic         s_tuser,   // cmd
    output logic         m_tvalid,
    input  logic         m_tready,
    // seq_number[31:0], out_type[47:32], out_proc_id[79:48],
    // out_arg_zero[111:80], out_arg_one[143:112], out_arg_two[175:144],
    // out_arg_three[207:176]
    output logic [207:0] m_tdata,
    output logic         m_tlast    // last_of_dump
);

    localparam int SLOT_W = $clog2(RING_DEPTH);
    localparam int CMD_W  = $bits(etr_cmd_t);
    localparam int Q_W    = SLOT_W + CMD_W;

    etr_entry_t        in_entry;
    logic [CNT_W-1:0]  in_limit;
    logic              push_valid, push_ready;
    logic [SLOT_W-1:0] push_slot;
    etr_cmd_t          push_cmd;
    logic [Q_W-1:0]    q_in, q_out;
    logic              q_valid, q_ready;
    logic [SLOT_W-1:0] q_slot;
    etr_cmd_t          q_cmd;
    etr_out_t          out_beat;

    // Unpack the input beat
    assign in_entry.event_type = s_tdata[15:0];
    assign in_entry.proc_id    = s_tdata[47:16];
    assign in_entry.arg_zero   = s_tdata[79:48];
    assign in_entry.arg_one    = s_tdata[111:80];
    assign in_entry.arg_two    = s_tdata[143:112];
    assign in_entry.arg_three  = s_tdata[175:144];
    assign in_limit            = s_tdata[182:176];

    etr_front #(
        .RING_DEPTH (RING_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_dump    (s_tuser),
        .in_entry   (in_entry),
        .in_limit   (in_limit),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_slot  (push_slot),
        .push_cmd   (push_cmd)
    );

    assign q_in   = {push_slot, push_cmd};
    assign q_slot = q_out[Q_W-1:CMD_W];
    assign q_cmd  = q_out[CMD_W-1:0];

    etr_fifo #(
        .DEPTH  (4),
        .DATA_W (Q_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (q_in),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_out)
    );

    etr_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd_slot  (q_slot),
        .cmd       (q_cmd),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_beat  (out_beat)
    );

    // Pack the output beat
    assign m_tdata = {out_beat.entry.arg_three, out_beat.entry.arg_two,
                      out_beat.entry.arg_one, out_beat.entry.arg_zero,
                      out_beat.entry.proc_id, out_beat.entry.event_type,
                      out_beat.seq};
    assign m_tlast = out_beat.last;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking regression for the event trace ring recorder. A local ring
// model tracks every accepted record and turns each accepted dump into the
// beats it should stream. A monitor compares every output beat against the
// oldest of those, while the sender bursts and the receiver stalls at random.
// ----------------------------------------------------------------------------
module tb;
    import etr_pkg::*;

    localparam int DEPTH      = 64;
    localparam int SLOT_W     = $clog2(DEPTH);
    localparam int MAX_LIMIT  = 64;
    localparam int RAND_ITEMS = 110;

    typedef enum logic {
        CMD_RECORD = 1'b0,
        CMD_DUMP   = 1'b1
    } trace_cmd_e;

    // DUT ports; the driven inputs are known from time zero
    logic         clk      = 1'b0;
    logic         rst_n    = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // event_type[15:0], proc_id[47:16], arg_zero[79:48], arg_one[111:80],
    // arg_two[143:112], arg_three[175:144], dump_limit[182:176], zero pad
    logic [183:0] s_tdata  = '0;
    logic         s_tuser  = 1'b0;   // cmd
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // seq_number[31:0], out_type[47:32], out_proc_id[79:48],
    // out_arg_zero[111:80], out_arg_one[143:112], out_arg_two[175:144],
    // out_arg_three[207:176]
    logic [207:0] m_tdata;
    logic         m_tlast;           // last_of_dump

    // Ring model and expected dump beats
    etr_entry_t   ring_copy [DEPTH];
    logic [31:0]  records_held_total = '0;
    etr_out_t     dump_beats_due [$];

    // Run bookkeeping
    int errors        = 0;
    int records_sent  = 0;
    int dumps_sent    = 0;
    int beats_checked = 0;
    int longest_dump  = 0;

    // Sender burst shaping
    int  burst_left = 0;
    bit  gaps_on    = 1'b1;

    // Receiver stall shaping
    int  ready_mode  = 0;
    int  mode_timer  = 0;
    int  stall_left  = 0;

    etr_out_t   want_beat;
    etr_entry_t seen_entry;

    event_trace_ring_recorder_unit #(
        .RING_DEPTH(DEPTH)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #4 clk = ~clk;

    // Update the ring copy on a record; queue the expected beats of a dump
    function automatic void predict_trace(trace_cmd_e cmd, etr_entry_t ev,
                                          logic [CNT_W-1:0] limit);
        logic [31:0] held;
        logic [31:0] count;
        logic [31:0] base;
        logic [31:0] pos;
        etr_out_t    beat;
        if (cmd == CMD_RECORD)
        begin
            ring_copy[records_held_total[SLOT_W-1:0]] = ev;
            records_held_total = records_held_total + 32'd1;
        end
        else if (records_held_total != 32'd0)
        begin
            held  = (records_held_total > 32'(DEPTH)) ? 32'(DEPTH) : records_held_total;
            count = (limit != '0 && 32'(limit) < held) ? 32'(limit) : held;
            base  = records_held_total - count;
            for (int k = 0; k < count; k++)
            begin
                pos        = base + 32'(k);
                beat.seq   = pos + 32'd1;
                beat.entry = ring_copy[pos[SLOT_W-1:0]];
                beat.last  = (k + 1 == count);
                dump_beats_due.push_back(beat);
            end
            if (count > longest_dump)
                longest_dump = count;
        end
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endfunction

    // Mostly random words, with the extremes mixed in
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic etr_entry_t random_event();
        etr_entry_t ev;
        ev.event_type = 16'(pick_word());
        ev.proc_id    = ($urandom_range(0, 5) == 0) ? 32'd0 : pick_word();
        ev.arg_zero   = pick_word();
        ev.arg_one    = pick_word();
        ev.arg_two    = pick_word();
        ev.arg_three  = pick_word();
        return ev;
    endfunction

    function automatic etr_entry_t fill_event(logic [31:0] word);
        etr_entry_t ev;
        ev.event_type = word[15:0];
        ev.proc_id    = word;
        ev.arg_zero   = word;
        ev.arg_one    = word;
        ev.arg_two    = word;
        ev.arg_three  = word;
        return ev;
    endfunction

    // Drive one beat, wait for the handshake, then predict it
    task automatic send_beat(trace_cmd_e cmd, etr_entry_t ev, logic [CNT_W-1:0] limit);
        int gap;
        if (gaps_on && burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {1'b0, limit, ev};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (burst_left > 0)
            burst_left--;
        if (cmd == CMD_RECORD)
            records_sent++;
        else
            dumps_sent++;
        predict_trace(cmd, ev, limit);
    endtask

    task automatic send_record(etr_entry_t ev);
        send_beat(CMD_RECORD, ev, CNT_W'($urandom_range(0, MAX_LIMIT)));
    endtask

    // A dump carries random junk in the fields it ignores
    task automatic send_dump(int limit);
        send_beat(CMD_DUMP, random_event(), limit[CNT_W-1:0]);
    endtask

    // Hold the sender until every expected beat has come out
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (dump_beats_due.size() != 0)
            @(posedge clk);
    endtask

    // Dumps before any record must stay silent
    task automatic test_empty_ring();
        send_dump(0);
        send_dump(MAX_LIMIT);
        send_dump(1);
        wait_for_drain();
        repeat (12) @(posedge clk);
    endtask

    // Extreme payloads, then limits of zero, one, below, equal and beyond held
    task automatic test_field_extremes();
        etr_entry_t ev;
        send_record(fill_event(32'h0000_0000));
        send_record(fill_event(32'hFFFF_FFFF));
        send_record(fill_event(32'h5555_5555));
        send_record(fill_event(32'hAAAA_AAAA));
        ev            = fill_event(32'h8000_0001);
        ev.event_type = 16'hFFFF;
        ev.proc_id    = 32'd0;
        send_record(ev);
        send_dump(0);
        send_dump(1);
        send_dump(4);
        send_dump(5);
        send_dump(MAX_LIMIT);
    endtask

    // Records and dumps back to back with no sender gaps
    task automatic test_back_to_back();
        gaps_on = 1'b0;
        send_record(random_event());
        send_dump(2);
        send_record(random_event());
        send_record(random_event());
        send_dump(0);
        send_record(random_event());
        gaps_on = 1'b1;
    endtask

    // Dump from a fully quiet block, then record into it again
    task automatic test_quiet_dump();
        wait_for_drain();
        send_dump(3);
        wait_for_drain();
        send_record(random_event());
    endtask

    // Mostly records with random dumps; the ring wraps well past its depth
    task automatic test_random_traffic();
        int lim;
        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                case ($urandom_range(0, 5))
                    0: lim = 0;
                    1: lim = MAX_LIMIT;
                    2: lim = $urandom_range(DEPTH - 2, MAX_LIMIT);
                    default: lim = $urandom_range(1, 16);
                endcase
                send_dump(lim);
            end
            else
            begin
                send_record(random_event());
            end
            if (i % 45 == 44)
                wait_for_drain();
        end
        // one full-ring dump once the ring has surely wrapped
        send_dump(0);
    endtask

    // Receiver: rotate between always ready, random, sparse and long stalls
    always @(posedge clk)
    begin
        if (mode_timer == 0)
        begin
            ready_mode <= $urandom_range(0, 3);
            mode_timer <= $urandom_range(20, 80);
        end
        else
        begin
            mode_timer <= mode_timer - 1;
        end
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else
        begin
            case (ready_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= ($urandom_range(0, 3) == 0);
                default:
                begin
                    m_tready <= 1'b1;
                    if ($urandom_range(0, 15) == 0)
                        stall_left <= $urandom_range(5, 30);
                end
            endcase
        end
    end

    // Monitor: compare each output beat with the oldest expected one
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (dump_beats_due.size() == 0)
            begin
                $display("%0t: unexpected beat: expected none, actual %h last %b",
                         $time, m_tdata, m_tlast);
                errors++;
            end
            else
            begin
                want_beat  = dump_beats_due.pop_front();
                seen_entry = m_tdata[207:32];
                check_field("seq_number", want_beat.seq, m_tdata[31:0]);
                check_field("out_type", 32'(want_beat.entry.event_type),
                            32'(seen_entry.event_type));
                check_field("out_proc_id", want_beat.entry.proc_id, seen_entry.proc_id);
                check_field("out_arg_zero", want_beat.entry.arg_zero, seen_entry.arg_zero);
                check_field("out_arg_one", want_beat.entry.arg_one, seen_entry.arg_one);
                check_field("out_arg_two", want_beat.entry.arg_two, seen_entry.arg_two);
                check_field("out_arg_three", want_beat.entry.arg_three,
                            seen_entry.arg_three);
                check_field("last_of_dump", 32'(want_beat.last), 32'(m_tlast));
                beats_checked++;
            end
        end
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("event_trace_ring_recorder_unit regression: fail");
        $finish;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_ring();
        test_field_extremes();
        test_back_to_back();
        test_quiet_dump();
        test_random_traffic();

        // Drain, then let any trailing beat show up
        wait_for_drain();
        repeat (16) @(posedge clk);

        $display("covered %0d records and %0d dumps (longest %0d entries) on a %0d-deep ring",
                 records_sent, dumps_sent, longest_dump, DEPTH);
        $display("checked %0d dump beats, %0d errors", beats_checked, errors);
        if (errors == 0)
            $display("event_trace_ring_recorder_unit regression: pass");
        else
            $display("event_trace_ring_recorder_unit regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/etr_pkg.sv
sv/etr_fifo.sv
sv/etr_front.sv
sv/etr_back.sv
sv/event_trace_ring_recorder_unit.sv
dv/tb.sv
